// File: rtl/core/csvft_pkg.sv
`default_nettype none
package csvft_pkg;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam int LEN_W = 12;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 12'd255;

    // register indexes
    localparam logic REG_MAX_LEN = 1'b0;

    localparam logic [1:0] NRES_NONE = 2'd0;
    localparam logic [1:0] NRES_ONE  = 2'd1;
    localparam logic [1:0] NRES_TWO  = 2'd2;

    typedef enum logic [2:0] {
        MODE_BEGIN  = 3'd0,
        MODE_BREAK  = 3'd1,
        MODE_COMMA  = 3'd2,
        MODE_UNQ    = 3'd3,
        MODE_QUOTED = 3'd4,
        MODE_QSEEN  = 3'd5
    } mode_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       field_end;
        logic       record_end;
        logic       stream_end;
        logic       truncated;
        logic       last_of_run;
    } res_t;

    // up to two results produced by one request
    typedef struct packed {
        logic [1:0] count;
        res_t       res0;
        res_t       res1;
    } res_pair_t;

endpackage
`default_nettype wire

// File: rtl/core/csvft_cfg.sv
`default_nettype none
module csvft_cfg (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic [csvft_pkg::LEN_W-1:0] max_len
);

    logic [csvft_pkg::LEN_W-1:0] max_len_reg;
    logic                        wr_en;
    logic                        idx;

    assign idx    = paddr[2];
    assign wr_en  = psel && penable && pwrite && (idx == csvft_pkg::REG_MAX_LEN);
    assign pready = 1'b1;
    assign max_len = max_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= csvft_pkg::MAX_LEN_RESET;
        end
        else if (wr_en)
        begin
            max_len_reg <= pwdata[csvft_pkg::LEN_W-1:0];
        end
    end

    always_comb
    begin
        if (idx == csvft_pkg::REG_MAX_LEN)
        begin
            prdata = {{(32-csvft_pkg::LEN_W){1'b0}}, max_len_reg};
        end
        else
        begin
            prdata = 32'd0;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/csvft_parser.sv
`default_nettype none
module csvft_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic        kind,
    input  wire logic [7:0]  in_byte,
    input  wire logic [csvft_pkg::LEN_W-1:0] max_len,
    output csvft_pkg::res_pair_t results
);

    csvft_pkg::mode_t            mode_reg, mode_next;
    logic [csvft_pkg::LEN_W-1:0] count_reg, count_next;
    logic                        ovf_reg, ovf_next;
    logic                        keep;
    logic                        is_break;
    csvft_pkg::res_t             r0, r1, byte_res, end_res;
    logic [1:0]                  n;

    assign keep     = count_reg < max_len;
    assign is_break = (in_byte == csvft_pkg::CH_CR) || (in_byte == csvft_pkg::CH_LF);

    always_comb
    begin
        byte_res = '0;
        byte_res.out_byte   = in_byte;
        byte_res.byte_valid = 1'b1;
        end_res = '0;
        end_res.field_end = 1'b1;
        end_res.truncated = ovf_reg;

        r0 = '0;
        r1 = '0;
        n  = csvft_pkg::NRES_NONE;
        mode_next  = mode_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;

        if (kind)
        begin
            if (mode_reg == csvft_pkg::MODE_BEGIN || mode_reg == csvft_pkg::MODE_BREAK)
            begin
                r0.stream_end = 1'b1;
            end
            else
            begin
                r0 = end_res;
                r0.record_end = 1'b1;
                r0.stream_end = 1'b1;
            end
            n = csvft_pkg::NRES_ONE;
            count_next = '0;
            ovf_next   = 1'b0;
            mode_next  = csvft_pkg::MODE_BEGIN;
        end
        else
        begin
            case (mode_reg)
                csvft_pkg::MODE_UNQ, csvft_pkg::MODE_QSEEN:
                begin
                    if (mode_reg == csvft_pkg::MODE_QSEEN && in_byte == csvft_pkg::CH_QUOTE)
                    begin
                        if (keep)
                        begin
                            r0 = byte_res;
                            n  = csvft_pkg::NRES_ONE;
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                        mode_next = csvft_pkg::MODE_QUOTED;
                    end
                    else if (in_byte == csvft_pkg::CH_COMMA || is_break)
                    begin
                        r0 = end_res;
                        r0.record_end = is_break;
                        n  = csvft_pkg::NRES_ONE;
                        count_next = '0;
                        ovf_next   = 1'b0;
                        mode_next  = is_break ? csvft_pkg::MODE_BREAK : csvft_pkg::MODE_COMMA;
                    end
                    else if (mode_reg == csvft_pkg::MODE_QSEEN)
                    begin
                        // text after closing quote: close field, start a new one
                        r0 = end_res;
                        mode_next = csvft_pkg::MODE_UNQ;
                        if (max_len != '0)
                        begin
                            r1 = byte_res;
                            n  = csvft_pkg::NRES_TWO;
                            count_next = {{(csvft_pkg::LEN_W-1){1'b0}}, 1'b1};
                            ovf_next   = 1'b0;
                        end
                        else
                        begin
                            n = csvft_pkg::NRES_ONE;
                            count_next = '0;
                            ovf_next   = 1'b1;
                        end
                    end
                    else if (keep)
                    begin
                        r0 = byte_res;
                        n  = csvft_pkg::NRES_ONE;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                csvft_pkg::MODE_QUOTED:
                begin
                    if (in_byte == csvft_pkg::CH_QUOTE)
                    begin
                        mode_next = csvft_pkg::MODE_QSEEN;
                    end
                    else if (keep)
                    begin
                        r0 = byte_res;
                        n  = csvft_pkg::NRES_ONE;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                default:
                begin
                    // field start
                    if (is_break)
                    begin
                        if (mode_reg != csvft_pkg::MODE_BREAK)
                        begin
                            r0 = end_res;
                            r0.record_end = 1'b1;
                            n  = csvft_pkg::NRES_ONE;
                            count_next = '0;
                            ovf_next   = 1'b0;
                        end
                        mode_next = csvft_pkg::MODE_BREAK;
                    end
                    else if (in_byte == csvft_pkg::CH_COMMA)
                    begin
                        r0 = end_res;
                        n  = csvft_pkg::NRES_ONE;
                        count_next = '0;
                        ovf_next   = 1'b0;
                        mode_next  = csvft_pkg::MODE_COMMA;
                    end
                    else if (in_byte == csvft_pkg::CH_QUOTE)
                    begin
                        mode_next = csvft_pkg::MODE_QUOTED;
                    end
                    else
                    begin
                        if (keep)
                        begin
                            r0 = byte_res;
                            n  = csvft_pkg::NRES_ONE;
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                        mode_next = csvft_pkg::MODE_UNQ;
                    end
                end
            endcase
        end

        if (n == csvft_pkg::NRES_ONE)
        begin
            r0.last_of_run = 1'b1;
        end
        if (n == csvft_pkg::NRES_TWO)
        begin
            r1.last_of_run = 1'b1;
        end

        results.count = accept ? n : csvft_pkg::NRES_NONE;
        results.res0  = r0;
        results.res1  = r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= csvft_pkg::MODE_BEGIN;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/csvft_outq.sv
`default_nettype none
module csvft_outq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire csvft_pkg::res_pair_t wr,
    output logic                     full,
    output logic                     rd_valid,
    input  wire logic                rd_stall,
    output csvft_pkg::res_t          rd_data
);

    csvft_pkg::res_t mem_reg [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;
    logic [1:0] wr_ptr_1;

    assign rd_valid = cnt_reg != 3'd0;
    // room for two results must be there before a request is taken
    assign full     = cnt_reg > 3'd2;
    assign pop      = rd_valid && !rd_stall;
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign wr_ptr_1 = wr_ptr_reg + 2'd1;

    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, wr.count} - {2'b00, pop};
    end

    always_ff @(posedge clk)
    begin
        if (wr.count != csvft_pkg::NRES_NONE)
        begin
            mem_reg[wr_ptr_reg] <= wr.res0;
        end
        if (wr.count == csvft_pkg::NRES_TWO)
        begin
            mem_reg[wr_ptr_1] <= wr.res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + wr.count;
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/csv_field_tokenizer.sv
// CSV field tokenizer.
// Input channel: in_valid / in_stall carry one request per cycle while in_stall is low, either a data
// byte (kind = 0, in_byte) or an end-of-stream mark (kind = 1).
// Output channel: out_valid / out_stall carry one result per cycle while out_stall is low: a kept field
// byte (byte_valid) or a field close (field_end, record_end, truncated), with
// stream_end on the end-of-stream result and last_of_run on the final result
// of each request.
// Throughput: one request per cycle while in_stall is low. Each request is parsed in the cycle it is
// accepted and its zero, one or two results land in a four-entry output queue;
// out_valid rises in the cycle after acceptance when the queue is empty.
// The queue sets the rate: in_stall rises while it holds three or more results,
// so requests that yield two results fill it faster than it drains.
// A stalled receiver fills the queue, then in_stall holds off further requests.
// The APB port holds max_field_len at offset 0 (reset 255); write it only idle.
// Reset (rst_n low) empties the queue and returns the parser to stream start.
`default_nettype none
module csv_field_tokenizer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        kind,
    input  wire logic [7:0]  in_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             byte_valid,
    output logic             field_end,
    output logic             record_end,
    output logic             stream_end,
    output logic             truncated,
    output logic             last_of_run,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [csvft_pkg::LEN_W-1:0] max_len;
    logic                        accept;
    logic                        full;
    csvft_pkg::res_pair_t        results;
    csvft_pkg::res_t             head;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    csvft_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .max_len (max_len)
    );

    csvft_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .kind    (kind),
        .in_byte (in_byte),
        .max_len (max_len),
        .results (results)
    );

    csvft_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (results),
        .full     (full),
        .rd_valid (out_valid),
        .rd_stall (out_stall),
        .rd_data  (head)
    );

    assign out_byte    = head.out_byte;
    assign byte_valid  = head.byte_valid;
    assign field_end   = head.field_end;
    assign record_end  = head.record_end;
    assign stream_end  = head.stream_end;
    assign truncated   = head.truncated;
    assign last_of_run = head.last_of_run;

endmodule
`default_nettype wire

// File: rtl/core/csvft_checker.sv
`default_nettype none
module csvft_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] out_byte,
    input wire logic       byte_valid,
    input wire logic       field_end,
    input wire logic       record_end,
    input wire logic       stream_end,
    input wire logic       truncated,
    input wire logic       last_of_run
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte)
            && $stable(field_end) && $stable(last_of_run))
    else $error("stalled result changed");

    // record end and truncation only come with a field close
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !field_end |-> !record_end && !truncated)
    else $error("end marks without field_end");

    // a byte result carries no end marks
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_valid |-> !field_end && !stream_end)
    else $error("byte result with end marks");

    // end of stream is the last result of its request and closes any record
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stream_end |-> last_of_run && (record_end == field_end))
    else $error("bad stream end result");

    // with nothing queued the input is never held off
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

endmodule

bind csv_field_tokenizer csvft_checker u_csvft_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .byte_valid  (byte_valid),
    .field_end   (field_end),
    .record_end  (record_end),
    .stream_end  (stream_end),
    .truncated   (truncated),
    .last_of_run (last_of_run)
);
`default_nettype wire
